### rtl/i2c_master_bit_sequencer_core_assert.svh
// Assertion macros used by the I2C bit sequencer checker
`ifndef I2C_MASTER_BIT_SEQUENCER_CORE_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define I2CMS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante
`define I2CMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/i2cms_pkg.sv
// Package with word types, command codes and timing constants of the I2C bit sequencer
package i2cms_pkg;

    localparam int NUM_PORTS  = 3;
    localparam int LINE_W     = 3;
    localparam int PORT_W     = 2;
    localparam int PHASE_W    = 5;

    localparam logic [LINE_W-1:0] PORT_MASK = LINE_W'((1 << NUM_PORTS) - 1);
    localparam logic [7:0]        TX_MSB    = 8'h80;
    localparam logic [2:0]        LAST_BIT  = 3'd7;

    typedef enum logic [2:0] {
        FN_START     = 3'd0,
        FN_STOP      = 3'd1,
        FN_WRITE     = 3'd2,
        FN_READ      = 3'd3,
        FN_WAIT_ACK  = 3'd4,
        FN_SEND_ACK  = 3'd5,
        FN_SEND_NACK = 3'd6,
        FN_INVALID   = 3'd7
    } i2c_func_t;

    typedef struct packed {
        logic              cmd_valid;
        logic [2:0]        func;
        logic [PORT_W-1:0] port;
        logic [7:0]        tx_byte;
        logic [LINE_W-1:0] sda_sample;
    } in_word_t;

    typedef struct packed {
        logic [LINE_W-1:0] scl_lines;
        logic [LINE_W-1:0] sda_lines;
        logic              busy_res;
        logic              done_res;
        logic [7:0]        rx_byte;
        logic              nack_seen;
    } out_word_t;

    // Number of ticks each command takes
    function automatic logic [PHASE_W-1:0] cmd_len(input i2c_func_t fn);
        logic [PHASE_W-1:0] len;
        case (fn)
            FN_START:     len = 5'd3;
            FN_STOP:      len = 5'd2;
            FN_WRITE:     len = 5'd24;
            FN_READ:      len = 5'd16;
            FN_WAIT_ACK:  len = 5'd3;
            FN_SEND_ACK:  len = 5'd4;
            FN_SEND_NACK: len = 5'd3;
            default:      len = 5'd3;
        endcase
        return len;
    endfunction

endpackage

### rtl/i2c_master_bit_sequencer_core.sv
// I2C master bit sequencer: one bus tick per input word, one result word per tick.
// Each accepted word's result is registered: in the result register, or in the skid entry while the output stalls.
// Throughput: one word per cycle while the skid entry is free; the tick logic is a single pass from state to result.
// A two-entry output buffer (result register plus skid) keeps input open while a result waits.
// Reset (rst_n low, asynchronous): idle, lines released, read and ack state cleared, buffer empty.
module i2c_master_bit_sequencer_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  i2cms_pkg::in_word_t  in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output i2cms_pkg::out_word_t out_word
);
    import i2cms_pkg::*;

    // Sequencer state
    i2c_func_t          cmd_reg,   cmd_next;
    logic [PORT_W-1:0]  port_reg,  port_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [1:0]         sub_reg,   sub_next;
    logic               busy_reg,  busy_next;
    logic [7:0]         shift_reg, shift_next;
    logic               ack_reg,   ack_next;
    logic [7:0]         tx_reg,    tx_next;
    logic [LINE_W-1:0]  scl_reg,   scl_next;
    logic [LINE_W-1:0]  sda_reg,   sda_next;

    // Output buffer
    out_word_t out_word_reg,  out_word_next;
    logic      out_valid_reg, out_valid_next;
    out_word_t skid_word_reg, skid_word_next;
    logic      skid_valid_reg, skid_valid_next;

    logic      in_acc;
    logic      start_ok;
    logic      done;
    out_word_t result;

    // Drive or release one port's line
    function automatic logic [LINE_W-1:0] put_bit(
        input logic [LINE_W-1:0] lines,
        input logic [PORT_W-1:0] prt,
        input logic              v
    );
        logic [LINE_W-1:0] m;
        m = LINE_W'(1) << prt;
        return (v ? (lines | m) : (lines & ~m)) & PORT_MASK;
    endfunction

    assign in_ready = !skid_valid_reg;
    assign in_acc   = in_valid && in_ready;

    // Run one tick: take a new command when idle, then step the active one
    always_comb
    begin
        logic              smp;
        logic [PHASE_W-1:0] ph;
        logic [1:0]        sub;
        start_ok = !busy_reg && in_word.cmd_valid
                   && (i2c_func_t'(in_word.func) != FN_INVALID)
                   && (32'(in_word.port) < NUM_PORTS);
        cmd_next   = cmd_reg;
        port_next  = port_reg;
        phase_next = phase_reg;
        sub_next   = sub_reg;
        busy_next  = busy_reg;
        shift_next = shift_reg;
        ack_next   = ack_reg;
        tx_next    = tx_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        done       = 1'b0;

        if (start_ok)
        begin
            cmd_next   = i2c_func_t'(in_word.func);
            port_next  = in_word.port;
            phase_next = '0;
            sub_next   = '0;
            busy_next  = 1'b1;
            if (i2c_func_t'(in_word.func) == FN_WRITE)
                tx_next = in_word.tx_byte;
            if (i2c_func_t'(in_word.func) == FN_READ)
                shift_next = '0;
        end

        ph  = phase_next;
        sub = sub_next;
        smp = in_word.sda_sample[port_next];

        if (busy_next)
        begin
            case (cmd_next)
                FN_START:
                begin
                    if (ph == 5'd0)
                    begin
                        sda_next = put_bit(sda_next, port_next, 1'b1);
                        scl_next = put_bit(scl_next, port_next, 1'b1);
                    end
                    else if (ph == 5'd1)
                        sda_next = put_bit(sda_next, port_next, 1'b0);
                    else
                        scl_next = put_bit(scl_next, port_next, 1'b0);
                end
                FN_STOP:
                begin
                    if (ph == 5'd0)
                    begin
                        sda_next = put_bit(sda_next, port_next, 1'b0);
                        scl_next = put_bit(scl_next, port_next, 1'b1);
                    end
                    else
                        sda_next = put_bit(sda_next, port_next, 1'b1);
                end
                FN_WRITE:
                begin
                    if (sub == 2'd0)
                        sda_next = put_bit(sda_next, port_next, (tx_next & TX_MSB) != 8'd0);
                    else if (sub == 2'd1)
                        scl_next = put_bit(scl_next, port_next, 1'b1);
                    else
                    begin
                        scl_next = put_bit(scl_next, port_next, 1'b0);
                        // Release SDA at the close of the last bit
                        if (ph == 5'd23)
                            sda_next = put_bit(sda_next, port_next, 1'b1);
                        tx_next = {tx_next[6:0], 1'b0};
                    end
                end
                FN_READ:
                begin
                    if (!ph[0])
                    begin
                        scl_next   = put_bit(scl_next, port_next, 1'b1);
                        shift_next = {shift_next[6:0], smp};
                    end
                    else
                        scl_next = put_bit(scl_next, port_next, 1'b0);
                end
                FN_WAIT_ACK:
                begin
                    if (ph == 5'd0)
                        sda_next = put_bit(sda_next, port_next, 1'b1);
                    else if (ph == 5'd1)
                    begin
                        scl_next = put_bit(scl_next, port_next, 1'b1);
                        ack_next = smp;
                    end
                    else
                        scl_next = put_bit(scl_next, port_next, 1'b0);
                end
                FN_SEND_ACK:
                begin
                    if (ph == 5'd0)
                        sda_next = put_bit(sda_next, port_next, 1'b0);
                    else if (ph == 5'd1)
                        scl_next = put_bit(scl_next, port_next, 1'b1);
                    else if (ph == 5'd2)
                        scl_next = put_bit(scl_next, port_next, 1'b0);
                    else
                        sda_next = put_bit(sda_next, port_next, 1'b1);
                end
                default:
                begin
                    if (ph == 5'd0)
                        sda_next = put_bit(sda_next, port_next, 1'b1);
                    else if (ph == 5'd1)
                        scl_next = put_bit(scl_next, port_next, 1'b1);
                    else
                        scl_next = put_bit(scl_next, port_next, 1'b0);
                end
            endcase

            // Advance the phase and finish on the last tick
            phase_next = ph + 5'd1;
            sub_next   = (sub == 2'd2) ? 2'd0 : sub + 2'd1;
            if (phase_next >= cmd_len(cmd_next))
            begin
                busy_next  = 1'b0;
                phase_next = '0;
                sub_next   = '0;
                done       = 1'b1;
            end
        end

        result.scl_lines = scl_next;
        result.sda_lines = sda_next;
        result.busy_res  = busy_next;
        result.done_res  = done;
        result.rx_byte   = shift_next;
        result.nack_seen = ack_next;
    end

    // Steer results into the output register or the skid entry
    always_comb
    begin
        out_word_next   = out_word_reg;
        out_valid_next  = out_valid_reg;
        skid_word_next  = skid_word_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || out_ready)
        begin
            out_valid_next  = skid_valid_reg || in_acc;
            out_word_next   = skid_valid_reg ? skid_word_reg : result;
            skid_valid_next = 1'b0;
        end
        else if (in_acc)
        begin
            skid_word_next  = result;
            skid_valid_next = 1'b1;
        end
    end

    // Hold sequencer state; update only on an accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg   <= FN_START;
            port_reg  <= '0;
            phase_reg <= '0;
            sub_reg   <= '0;
            busy_reg  <= 1'b0;
            shift_reg <= '0;
            ack_reg   <= 1'b0;
            tx_reg    <= '0;
            scl_reg   <= PORT_MASK;
            sda_reg   <= PORT_MASK;
        end
        else if (in_acc)
        begin
            cmd_reg   <= cmd_next;
            port_reg  <= port_next;
            phase_reg <= phase_next;
            sub_reg   <= sub_next;
            busy_reg  <= busy_next;
            shift_reg <= shift_next;
            ack_reg   <= ack_next;
            tx_reg    <= tx_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
        end
    end

    // Buffer valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Buffer payload
    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

### rtl/i2cms_checker.sv
// Port checker for the I2C bit sequencer and its bind to the top level
`include "i2c_master_bit_sequencer_core_assert.svh"

module i2cms_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input i2cms_pkg::out_word_t out_word
);
    import i2cms_pkg::*;

    // Hold a stalled result word
    `I2CMS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word), "stalled result word dropped or changed")

    // Never flag a command both running and finished
    `I2CMS_ASSERT_SAME(a_busy_done, out_valid, !(out_word.busy_res && out_word.done_res), "busy and done both set")

    // Empty output implies the skid entry is free
    `I2CMS_ASSERT_SAME(a_ready_empty, !out_valid, in_ready, "input blocked with no result pending")

    // When a done result is taken while the skid entry is full, the output stays valid
    `I2CMS_ASSERT_NEXT(a_done_taken, out_valid && out_ready && out_word.done_res && !in_ready, out_valid, "skid word lost after done")

endmodule

bind i2c_master_bit_sequencer_core i2cms_checker u_i2cms_checker (.*);

### tb/i2c_master_bit_sequencer_core_test.sv
// Self-checking bench for the I2C bit sequencer core: tick stream in, per-tick line state out
module i2c_master_bit_sequencer_core_test;
    import i2cms_pkg::*;

    localparam int CLK_HALF   = 10;
    localparam int RESET_CYC  = 7;
    localparam int TICK_GOAL  = 650;
    localparam int CALM_TAIL  = 100;
    localparam int SETTLE_CYC = 8;
    localparam int CYCLE_CAP  = 400000;
    localparam int SHOW_MAX   = 10;
    localparam int RANDOM_PIN = -1;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_word_t  in_word   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_word;

    // pending ticks and the line state each accepted tick must produce
    in_word_t  tick_q[$];
    bit        drain_q[$];
    out_word_t want_q[$];

    // bus model state
    i2c_func_t          bus_fn    = FN_START;
    logic [PORT_W-1:0]  bus_port  = '0;
    logic [PHASE_W-1:0] bus_phase = '0;
    logic               bus_busy  = 1'b0;
    logic [7:0]         rx_shift  = '0;
    logic [7:0]         tx_shift  = '0;
    logic               ack_level = 1'b0;
    logic [LINE_W-1:0]  scl_q     = PORT_MASK;
    logic [LINE_W-1:0]  sda_q     = PORT_MASK;

    int send_gap       = 0;
    int recv_stall     = 0;
    int ticks_sent     = 0;
    int results_seen   = 0;
    int cmds_started   = 0;
    int offers_ignored = 0;
    int faults         = 0;
    int cycle_count    = 0;

    i2c_master_bit_sequencer_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    always #CLK_HALF clk = ~clk;

    // ticks a command occupies on the bus
    function automatic int ticks_for(input i2c_func_t fn);
        case (fn)
            FN_START:    return 3;
            FN_STOP:     return 2;
            FN_WRITE:    return 24;
            FN_READ:     return 16;
            FN_SEND_ACK: return 4;
            default:     return 3;
        endcase
    endfunction

    // set or release the active port's line, keep the others
    function automatic logic [LINE_W-1:0] line_with(input logic [LINE_W-1:0] lines,
                                                    input logic v);
        logic [LINE_W-1:0] m;
        m = LINE_W'(1) << bus_port;
        return (v ? (lines | m) : (lines & ~m)) & PORT_MASK;
    endfunction

    // advance the bus model by one tick and return the line state it leaves
    function automatic out_word_t advance_bus(input in_word_t w);
        out_word_t r;
        logic      fin;
        logic      pin;
        int        sub;
        int        bitn;
        fin = 1'b0;
        if (!bus_busy && w.cmd_valid && w.func != FN_INVALID && w.port < NUM_PORTS) begin
            bus_fn    = i2c_func_t'(w.func);
            bus_port  = w.port;
            bus_phase = '0;
            bus_busy  = 1'b1;
            if (bus_fn == FN_WRITE)
                tx_shift = w.tx_byte;
            if (bus_fn == FN_READ)
                rx_shift = '0;
            cmds_started++;
        end else if (w.cmd_valid) begin
            offers_ignored++;
        end
        if (bus_busy) begin
            pin  = w.sda_sample[bus_port];
            sub  = int'(bus_phase) % 3;
            bitn = int'(bus_phase) / 3;
            case (bus_fn)
                FN_START: begin
                    if (bus_phase == 0) begin
                        sda_q = line_with(sda_q, 1'b1);
                        scl_q = line_with(scl_q, 1'b1);
                    end else if (bus_phase == 1) begin
                        sda_q = line_with(sda_q, 1'b0);
                    end else begin
                        scl_q = line_with(scl_q, 1'b0);
                    end
                end
                FN_STOP: begin
                    if (bus_phase == 0) begin
                        sda_q = line_with(sda_q, 1'b0);
                        scl_q = line_with(scl_q, 1'b1);
                    end else begin
                        sda_q = line_with(sda_q, 1'b1);
                    end
                end
                FN_WRITE: begin
                    if (sub == 0) begin
                        sda_q = line_with(sda_q, (tx_shift & TX_MSB) != 0);
                    end else if (sub == 1) begin
                        scl_q = line_with(scl_q, 1'b1);
                    end else begin
                        scl_q = line_with(scl_q, 1'b0);
                        // release SDA after the last bit for the acknowledge slot
                        if (bitn == int'(LAST_BIT))
                            sda_q = line_with(sda_q, 1'b1);
                        tx_shift = tx_shift << 1;
                    end
                end
                FN_READ: begin
                    if (bus_phase[0] == 1'b0) begin
                        scl_q    = line_with(scl_q, 1'b1);
                        rx_shift = {rx_shift[6:0], pin};
                    end else begin
                        scl_q = line_with(scl_q, 1'b0);
                    end
                end
                FN_WAIT_ACK: begin
                    if (bus_phase == 0) begin
                        sda_q = line_with(sda_q, 1'b1);
                    end else if (bus_phase == 1) begin
                        scl_q     = line_with(scl_q, 1'b1);
                        ack_level = pin;
                    end else begin
                        scl_q = line_with(scl_q, 1'b0);
                    end
                end
                FN_SEND_ACK: begin
                    if (bus_phase == 0)
                        sda_q = line_with(sda_q, 1'b0);
                    else if (bus_phase == 1)
                        scl_q = line_with(scl_q, 1'b1);
                    else if (bus_phase == 2)
                        scl_q = line_with(scl_q, 1'b0);
                    else
                        sda_q = line_with(sda_q, 1'b1);
                end
                default: begin
                    if (bus_phase == 0)
                        sda_q = line_with(sda_q, 1'b1);
                    else if (bus_phase == 1)
                        scl_q = line_with(scl_q, 1'b1);
                    else
                        scl_q = line_with(scl_q, 1'b0);
                end
            endcase
            bus_phase = bus_phase + 1'b1;
            if (int'(bus_phase) >= ticks_for(bus_fn)) begin
                bus_busy  = 1'b0;
                bus_phase = '0;
                fin       = 1'b1;
            end
        end
        r.scl_lines = scl_q;
        r.sda_lines = sda_q;
        r.busy_res  = bus_busy;
        r.done_res  = fin;
        r.rx_byte   = rx_shift;
        r.nack_seen = ack_level;
        return r;
    endfunction

    task automatic queue_tick(input logic v, input logic [2:0] fn, input logic [1:0] pt,
                              input logic [7:0] tx, input int pin, input bit drain);
        in_word_t w;
        w.cmd_valid  = v;
        w.func       = fn;
        w.port       = pt;
        w.tx_byte    = tx;
        w.sda_sample = (pin < 0) ? LINE_W'($urandom) : LINE_W'(pin);
        tick_q.push_back(w);
        drain_q.push_back(drain);
    endtask

    // one command from an idle bus, then its remaining ticks, with offers mixed in if noisy
    task automatic queue_cmd(input i2c_func_t fn, input logic [1:0] pt, input logic [7:0] tx,
                             input int pin, input bit noisy, input bit drain);
        int n;
        n = ticks_for(fn);
        queue_tick(1'b1, fn, pt, tx, pin, drain);
        for (int k = 1; k < n; k++) begin
            queue_tick(noisy && $urandom_range(0, 2) == 0, 3'($urandom), 2'($urandom),
                       8'($urandom), pin, 1'b0);
        end
    endtask

    // idle ticks: nothing offered, code seven, or a port out of range
    task automatic queue_idle(input int n);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 2))
                0:       queue_tick(1'b0, 3'($urandom), 2'($urandom), 8'($urandom),
                                    RANDOM_PIN, 1'b0);
                1:       queue_tick(1'b1, FN_INVALID, 2'($urandom), 8'($urandom),
                                    RANDOM_PIN, 1'b0);
                default: queue_tick(1'b1, 3'($urandom_range(0, 6)), 2'd3, 8'($urandom),
                                    RANDOM_PIN, 1'b0);
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            faults++;
            if (faults <= SHOW_MAX)
                $display("result %0d %s: expected %h, got %h", results_seen, name, want, got);
        end
    endtask

    // drive ticks from the queue, with random gaps between words
    always @(posedge clk) begin : drive_ticks
        bit        hold;
        bit        launch;
        in_word_t  next_w;
        out_word_t pred;
        if (rst_n) begin
            launch = 1'b0;
            next_w = in_word;
            hold   = in_valid && !in_ready;
            if (in_valid && in_ready) begin
                pred = advance_bus(in_word);
                want_q.push_back(pred);
                ticks_sent++;
            end
            if (!hold) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (tick_q.size() > 0 && !(drain_q[0] && want_q.size() > 0)) begin
                    next_w = tick_q.pop_front();
                    drain_q.delete(0);
                    launch = 1'b1;
                    if (tick_q.size() >= CALM_TAIL && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 18);
                end
            end
            in_valid <= hold || launch;
            in_word  <= next_w;
        end
    end

    // compare each result word with the oldest prediction; stall the output at random
    always @(posedge clk) begin : check_results
        out_word_t want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (want_q.size() == 0) begin
                    faults++;
                    if (faults <= SHOW_MAX)
                        $display("result word %h with nothing expected", out_word);
                end else begin
                    want = want_q.pop_front();
                    check_field("scl_lines", 8'(want.scl_lines), 8'(out_word.scl_lines));
                    check_field("sda_lines", 8'(want.sda_lines), 8'(out_word.sda_lines));
                    check_field("busy_res", 8'(want.busy_res), 8'(out_word.busy_res));
                    check_field("done_res", 8'(want.done_res), 8'(out_word.done_res));
                    check_field("rx_byte", want.rx_byte, out_word.rx_byte);
                    check_field("nack_seen", 8'(want.nack_seen), 8'(out_word.nack_seen));
                    results_seen++;
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                out_ready <= 1'b0;
            end else if (tick_q.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
                recv_stall = $urandom_range(0, 17);
                out_ready  <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // bound the run
    always @(posedge clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     want_q.size());
            $display("** i2c_master_bit_sequencer_core: FAILED **");
            $finish;
        end
    end

    initial begin : run_plan
        int         target;
        int         pick;
        logic [1:0] pt;
        bit         noisy;

        // idle tick, code seven and a port out of range are all ignored
        queue_tick(1'b0, FN_WRITE, 2'd0, 8'hFF, RANDOM_PIN, 1'b0);
        queue_tick(1'b1, FN_INVALID, 2'd0, 8'h00, RANDOM_PIN, 1'b0);
        queue_tick(1'b1, FN_START, 2'd3, 8'hFF, RANDOM_PIN, 1'b0);
        // port 0 transfer with all-ones data, acknowledged
        queue_cmd(FN_START, 2'd0, 8'h00, RANDOM_PIN, 1'b0, 1'b0);
        queue_cmd(FN_WRITE, 2'd0, 8'hFF, RANDOM_PIN, 1'b1, 1'b0);
        queue_cmd(FN_WAIT_ACK, 2'd0, 8'h00, 0, 1'b0, 1'b0);
        queue_cmd(FN_READ, 2'd0, 8'h00, 7, 1'b0, 1'b0);
        queue_cmd(FN_SEND_ACK, 2'd0, 8'h00, RANDOM_PIN, 1'b0, 1'b0);
        queue_cmd(FN_STOP, 2'd0, 8'h00, RANDOM_PIN, 1'b0, 1'b0);
        // port 2 transfer with all-zeros data, not acknowledged; hold until results drain
        queue_cmd(FN_START, 2'd2, 8'h00, RANDOM_PIN, 1'b0, 1'b1);
        queue_cmd(FN_WRITE, 2'd2, 8'h00, RANDOM_PIN, 1'b0, 1'b0);
        queue_cmd(FN_WAIT_ACK, 2'd2, 8'h00, 7, 1'b0, 1'b0);
        queue_cmd(FN_READ, 2'd2, 8'h00, 0, 1'b0, 1'b0);
        queue_cmd(FN_SEND_NACK, 2'd2, 8'h00, RANDOM_PIN, 1'b0, 1'b0);
        queue_cmd(FN_STOP, 2'd2, 8'h00, RANDOM_PIN, 1'b0, 1'b0);
        // port 1 with offers arriving while busy
        queue_cmd(FN_WRITE, 2'd1, 8'hA5, RANDOM_PIN, 1'b1, 1'b0);
        queue_cmd(FN_READ, 2'd1, 8'h00, RANDOM_PIN, 1'b1, 1'b0);
        queue_cmd(FN_WAIT_ACK, 2'd1, 8'h00, RANDOM_PIN, 1'b1, 1'b0);
        queue_idle(2);

        // random part: mostly whole transfers and single commands, some idle noise
        target = TICK_GOAL;
        while (tick_q.size() < target) begin
            pick  = $urandom_range(0, 9);
            pt    = 2'($urandom_range(0, NUM_PORTS - 1));
            noisy = $urandom_range(0, 1);
            if (pick < 2) begin
                queue_cmd(FN_START, pt, 8'h00, RANDOM_PIN, noisy, $urandom_range(0, 9) == 0);
                queue_cmd(FN_WRITE, pt, 8'($urandom), RANDOM_PIN, noisy, 1'b0);
                queue_cmd(FN_WAIT_ACK, pt, 8'h00, RANDOM_PIN, noisy, 1'b0);
                if ($urandom_range(0, 1)) begin
                    queue_cmd(FN_WRITE, pt, 8'($urandom), RANDOM_PIN, noisy, 1'b0);
                    queue_cmd(FN_WAIT_ACK, pt, 8'h00, RANDOM_PIN, noisy, 1'b0);
                end else begin
                    queue_cmd(FN_READ, pt, 8'h00, RANDOM_PIN, noisy, 1'b0);
                    queue_cmd($urandom_range(0, 1) ? FN_SEND_ACK : FN_SEND_NACK, pt, 8'h00,
                              RANDOM_PIN, noisy, 1'b0);
                end
                queue_cmd(FN_STOP, pt, 8'h00, RANDOM_PIN, noisy, 1'b0);
            end else if (pick < 9) begin
                queue_cmd(i2c_func_t'($urandom_range(0, 6)), pt, 8'($urandom), RANDOM_PIN,
                          noisy, $urandom_range(0, 39) == 0);
            end else begin
                queue_idle($urandom_range(1, 4));
            end
        end

        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;

        while (tick_q.size() > 0 || in_valid || want_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);

        if (want_q.size() > 0) begin
            faults += want_q.size();
            $display("%0d expected results never arrived", want_q.size());
        end
        $display("%0d ticks driven and %0d result words checked under random gaps and stalls",
                 ticks_sent, results_seen);
        $display("%0d commands run, %0d offers ignored (busy, code seven, port out of range)",
                 cmds_started, offers_ignored);
        if (faults == 0) begin
            $display("** i2c_master_bit_sequencer_core: PASSED **");
        end else begin
            $display("%0d mismatches", faults);
            $display("** i2c_master_bit_sequencer_core: FAILED **");
        end
        $finish;
    end

endmodule
